// File: src/ordered_array_list_engine_defines.svh
// Assertion macros shared by the ordered array list engine.
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge outside reset.
`define OALE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define OALE_NEVER(lbl, clk, rst_n, cond, msg) \
  `OALE_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define OALE_ASSERT(lbl, clk, rst_n, prop, msg)
`define OALE_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: src/oale_pkg.sv
// Types, codes and constants of the ordered array list engine.
`default_nettype none

package oale_pkg;

  // Default list capacity.
  localparam int unsigned OALE_CAPACITY = 64;

  // Fixed field widths of the request and response.
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT     = 3'd0,
    ACT_ERASE      = 3'd1,
    ACT_FIND       = 3'd2,
    ACT_MODIFY     = 3'd3,
    ACT_PUSH_BACK  = 3'd4,
    ACT_PUSH_FRONT = 3'd5,
    ACT_POP_BACK   = 3'd6,
    ACT_POP_FRONT  = 3'd7
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic [POS_W-1:0]          position;
    logic signed [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] count_after;
  } rsp_t;

  // Controller states.
  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_WRITE,
    CELL_COMPARE,
    CELL_SHIFT_HIT
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: src/oale_cell.sv
// One storage cell of the list chain: holds one entry and one match flag.
`default_nettype none

module oale_cell
  import oale_pkg::*;
#(
  parameter int unsigned Index = 0,
  parameter int unsigned PosW  = 7
) (
  input  wire logic                  clk_i,
  input  wire cell_cmd_t             cmd_i,
  input  wire logic [PosW-1:0]       pos_i,
  input  wire logic [VAL_W-1:0]      left_entry_i,
  input  wire logic [VAL_W-1:0]      right_entry_i,
  input  wire logic                  right_hit_i,
  output logic [VAL_W-1:0]           entry_o,
  output logic                       hit_o
);

  localparam logic [PosW-1:0] MyIdx = PosW'(Index);

  logic [VAL_W-1:0] entry_q, entry_d;
  logic             hit_q, hit_d;

  // Next entry and match flag for the broadcast operation.
  always_comb begin
    entry_d = entry_q;
    hit_d   = hit_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          entry_d = left_entry_i;
        end else if (MyIdx == pos_i) begin
          entry_d = cmd_i.value;
        end
      end
      CELL_ERASE: begin
        if (MyIdx >= pos_i) begin
          entry_d = right_entry_i;
        end
      end
      CELL_WRITE: begin
        if (MyIdx == pos_i) begin
          entry_d = cmd_i.value;
        end
      end
      CELL_COMPARE: begin
        hit_d = (entry_q == cmd_i.value);
      end
      CELL_SHIFT_HIT: begin
        hit_d = right_hit_i;
      end
      default: begin
      end
    endcase
  end

  // Entry and flag are payload and need no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

// File: src/oale_ctrl.sv
// Controller of the list engine: decodes requests, keeps the count, runs the find scan.
`default_nettype none

module oale_ctrl
  import oale_pkg::*;
#(
  parameter int unsigned Capacity = OALE_CAPACITY,
  parameter int unsigned CntW     = $clog2(Capacity + 1),
  parameter int unsigned IdxW     = $clog2(Capacity)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire req_t           in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rsp_t                out_rsp_o,
  output cell_cmd_t           cell_cmd_o,
  output logic [CntW-1:0]     cell_pos_o,
  input  wire logic           hit_head_i
);

  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  fsm_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  scan_q, scan_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, res;
  logic             res_load;
  logic             accept;
  logic [CmpW-1:0]  pos_ext, cnt_ext;
  logic             list_full, list_empty, scan_last;

  assign in_ready_o = (state_q == FSM_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext    = CmpW'(in_req_i.position);
  assign cnt_ext    = CmpW'(count_q);
  assign list_full  = (count_q == CntW'(Capacity));
  assign list_empty = (count_q == '0);
  assign scan_last  = (scan_q == IdxW'(count_q - CntW'(1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept && (in_req_i.action == ACT_FIND) && !list_empty) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (hit_head_i || scan_last) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Cell commands, count update and result.
  always_comb begin
    cell_cmd_o.op    = CELL_HOLD;
    cell_cmd_o.value = in_req_i.value;
    cell_pos_o       = CntW'(in_req_i.position);
    count_d          = count_q;
    scan_d           = scan_q;
    res_load         = 1'b0;
    res.status       = ST_OK;
    res.found_index  = '0;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (in_req_i.action)
            ACT_INSERT: begin
              if (pos_ext > cnt_ext) begin
                res.status = ST_BAD_POS;
              end else if (list_full) begin
                res.status = ST_FULL;
              end else begin
                cell_cmd_o.op = CELL_INSERT;
                count_d       = count_q + CntW'(1);
              end
            end
            ACT_ERASE: begin
              if (pos_ext >= cnt_ext) begin
                res.status = ST_BAD_POS;
              end else begin
                cell_cmd_o.op = CELL_ERASE;
                count_d       = count_q - CntW'(1);
              end
            end
            ACT_FIND: begin
              if (list_empty) begin
                res.status = ST_NOT_FOUND;
              end else begin
                res_load      = 1'b0;
                cell_cmd_o.op = CELL_COMPARE;
                scan_d        = '0;
              end
            end
            ACT_MODIFY: begin
              if (pos_ext >= cnt_ext) begin
                res.status = ST_BAD_POS;
              end else begin
                cell_cmd_o.op = CELL_WRITE;
              end
            end
            ACT_PUSH_BACK: begin
              if (list_full) begin
                res.status = ST_FULL;
              end else begin
                cell_cmd_o.op = CELL_INSERT;
                cell_pos_o    = count_q;
                count_d       = count_q + CntW'(1);
              end
            end
            ACT_PUSH_FRONT: begin
              if (list_full) begin
                res.status = ST_FULL;
              end else begin
                cell_cmd_o.op = CELL_INSERT;
                cell_pos_o    = '0;
                count_d       = count_q + CntW'(1);
              end
            end
            ACT_POP_BACK: begin
              if (list_empty) begin
                res.status = ST_EMPTY;
              end else begin
                cell_cmd_o.op = CELL_ERASE;
                cell_pos_o    = count_q - CntW'(1);
                count_d       = count_q - CntW'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (list_empty) begin
                res.status = ST_EMPTY;
              end else begin
                cell_cmd_o.op = CELL_ERASE;
                cell_pos_o    = '0;
                count_d       = count_q - CntW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_SCAN: begin
        // The match flags move one cell toward the head every cycle.
        if (hit_head_i) begin
          res_load        = 1'b1;
          res.found_index = IDX_W'(scan_q);
        end else if (scan_last) begin
          res_load   = 1'b1;
          res.status = ST_NOT_FOUND;
        end else begin
          cell_cmd_o.op = CELL_SHIFT_HIT;
          scan_d        = scan_q + IdxW'(1);
        end
      end
      default: begin
      end
    endcase
    res.count_after = CNT_W'(count_d);
  end

  // Output register holds a result until it is taken.
  assign out_valid_d = res_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// File: src/ordered_array_list_engine.sv
// Ordered array list engine: a chain of entry cells with its controller.
//
// The list lives in a chain of Capacity cells, one entry per cell. Insert,
// erase, modify, push and pop shift or write all cells at once, and a new
// request is accepted every cycle while the result register can drain. A
// find compares the key in every cell in the cycle of acceptance and then
// moves the match flags one cell toward the head per cycle until the first
// match or the last entry reaches cell zero; it holds the block until then.
// A find on an empty list does not scan. The result of every request waits
// in an output register; a new request is accepted in a cycle in which no
// find scans and that register is taken or empty.
`default_nettype none

`include "ordered_array_list_engine_defines.svh"

module ordered_array_list_engine
  import oale_pkg::*;
#(
  parameter int unsigned CAPACITY = OALE_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  cell_cmd_t        cell_cmd;
  logic [CntW-1:0]  cell_pos;
  logic [VAL_W-1:0] entry   [CAPACITY];
  logic             hit     [CAPACITY];

  // Request decode, count and find scan.
  oale_ctrl #(
    .Capacity (CAPACITY),
    .CntW     (CntW),
    .IdxW     (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cell_cmd_o  (cell_cmd),
    .cell_pos_o  (cell_pos),
    .hit_head_i  (hit[0])
  );

  // Chain of cells; each takes entries and match flags from its neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_entry, right_entry;
    logic             right_hit;

    if (g == 0) begin : g_head
      assign left_entry = '0;
    end else begin : g_body
      assign left_entry = entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_hit   = 1'b0;
    end else begin : g_inner
      assign right_entry = entry[g+1];
      assign right_hit   = hit[g+1];
    end

    oale_cell #(
      .Index (g),
      .PosW  (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cell_cmd),
      .pos_i         (cell_pos),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .right_hit_i   (right_hit),
      .entry_o       (entry[g]),
      .hit_o         (hit[g])
    );
  end

  // The block never takes a request while a result is stalled at the output.
  `OALE_NEVER(a_no_accept_when_stalled, clk_i, rst_ni,
    in_ready_o && out_valid_o && !out_ready_i, "request taken while result stalled")

  // A full list reports the capacity as its count.
  `OALE_ASSERT(a_full_count, clk_i, rst_ni,
    (out_valid_o && (out_rsp_o.status == ST_FULL)) |->
      (out_rsp_o.count_after == CNT_W'(CAPACITY)), "full status with wrong count")

  // An empty list reports a zero count.
  `OALE_ASSERT(a_empty_count, clk_i, rst_ni,
    (out_valid_o && (out_rsp_o.status == ST_EMPTY)) |->
      (out_rsp_o.count_after == '0), "empty status with nonzero count")

  // A missed find reports index zero.
  `OALE_ASSERT(a_miss_index, clk_i, rst_ni,
    (out_valid_o && (out_rsp_o.status == ST_NOT_FOUND)) |->
      (out_rsp_o.found_index == '0), "missed find with nonzero index")

endmodule

`default_nettype wire

// File: test/ordered_array_list_engine_tb.sv
// Self-checking testbench of the ordered array list engine with a list predictor.
`default_nettype none

module ordered_array_list_engine_tb;
  import oale_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 2000;

  typedef enum int unsigned {
    MIX_GROW,
    MIX_SHRINK,
    MIX_ANY
  } mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  // Predicted list contents and the responses still owed by the block.
  logic [VAL_W-1:0] list_q[$];
  rsp_t pending_rsp_q[$];
  rsp_t want_rsp;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit steady;

  ordered_array_list_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Free-running clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Inserts a value at a list position, shifting later entries up.
  function automatic status_e list_insert(int unsigned pos, logic [VAL_W-1:0] val);
    if (pos > list_q.size()) return ST_BAD_POS;
    if (list_q.size() >= OALE_CAPACITY) return ST_FULL;
    list_q.insert(pos, val);
    return ST_OK;
  endfunction

  // Removes the entry at a list position, shifting later entries down.
  function automatic status_e list_erase(int unsigned pos);
    if (pos >= list_q.size()) return ST_BAD_POS;
    list_q.delete(pos);
    return ST_OK;
  endfunction

  // Applies one request to the predicted list and returns the response it owes.
  function automatic rsp_t apply_list_action(req_t req);
    rsp_t rsp;
    int unsigned pos;
    rsp.status = ST_OK;
    rsp.found_index = '0;
    pos = req.position;
    case (req.action)
      ACT_INSERT: rsp.status = list_insert(pos, req.value);
      ACT_ERASE: rsp.status = list_erase(pos);
      ACT_FIND: begin
        rsp.status = ST_NOT_FOUND;
        for (int i = 0; i < list_q.size(); i++) begin
          if (list_q[i] == req.value) begin
            rsp.status = ST_OK;
            rsp.found_index = IDX_W'(i);
            break;
          end
        end
      end
      ACT_MODIFY: begin
        if (pos >= list_q.size()) rsp.status = ST_BAD_POS;
        else list_q[pos] = req.value;
      end
      ACT_PUSH_BACK: rsp.status = list_insert(list_q.size(), req.value);
      ACT_PUSH_FRONT: rsp.status = list_insert(0, req.value);
      ACT_POP_BACK: begin
        if (list_q.size() == 0) rsp.status = ST_EMPTY;
        else rsp.status = list_erase(list_q.size() - 1);
      end
      default: begin
        if (list_q.size() == 0) rsp.status = ST_EMPTY;
        else rsp.status = list_erase(0);
      end
    endcase
    rsp.count_after = CNT_W'(list_q.size());
    return rsp;
  endfunction

  // Sends one request, with an occasional gap before it, and predicts its response.
  task automatic send_request(action_e act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    req_t req;
    req.action = act;
    req.position = pos;
    req.value = val;
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp_q.push_back(apply_list_action(req));
  endtask

  // Holds the sender until every predicted response has been returned.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Picks a value, often from a small pool so that finds hit.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return VAL_W'($urandom_range(1, 6));
      default: return $urandom();
    endcase
  endfunction

  // Picks an action weighted toward growing, shrinking or neither.
  function automatic action_e pick_action(mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mix == MIX_GROW) begin
      if (r < 30) return ACT_PUSH_BACK;
      if (r < 48) return ACT_PUSH_FRONT;
      if (r < 65) return ACT_INSERT;
      if (r < 80) return ACT_FIND;
      if (r < 90) return ACT_MODIFY;
      if (r < 95) return ACT_ERASE;
      return ACT_POP_FRONT;
    end
    if (mix == MIX_SHRINK) begin
      if (r < 25) return ACT_POP_BACK;
      if (r < 43) return ACT_POP_FRONT;
      if (r < 63) return ACT_ERASE;
      if (r < 78) return ACT_FIND;
      if (r < 88) return ACT_MODIFY;
      return ACT_INSERT;
    end
    return action_e'($urandom_range(0, 7));
  endfunction

  // Picks a position that is mostly legal for the action on the current list.
  function automatic logic [POS_W-1:0] pick_position(action_e act);
    int unsigned n;
    n = list_q.size();
    if ($urandom_range(0, 99) < 10) return POS_W'($urandom_range(0, 127));
    if (act == ACT_INSERT) return POS_W'($urandom_range(0, n));
    if (n == 0) return '0;
    return POS_W'($urandom_range(0, n - 1));
  endfunction

  // Response checker: compares each returned response with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: response with none expected, actual %p", $time, out_rsp_o);
        mismatch_count++;
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (out_rsp_o.status !== want_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want_rsp.status,
                   out_rsp_o.status);
          mismatch_count++;
        end
        if (out_rsp_o.found_index !== want_rsp.found_index) begin
          $display("%0t: found_index expected %0d actual %0d", $time,
                   want_rsp.found_index, out_rsp_o.found_index);
          mismatch_count++;
        end
        if (out_rsp_o.count_after !== want_rsp.count_after) begin
          $display("%0t: count_after expected %0d actual %0d", $time,
                   want_rsp.count_after, out_rsp_o.count_after);
          mismatch_count++;
        end
      end
    end
  end

  // Response stalls, switched off during steady stretches.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 14);
  end

  // Watchdog on cycles in which neither side moves a request or response.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Actions on an empty list, then single entries and the value extremes.
  task automatic test_small_list();
    send_request(ACT_POP_BACK, 7'd0, 32'd0);
    send_request(ACT_POP_FRONT, 7'd0, 32'd0);
    send_request(ACT_ERASE, 7'd0, 32'd0);
    send_request(ACT_MODIFY, 7'd0, 32'd5);
    send_request(ACT_FIND, 7'd0, 32'd0);
    send_request(ACT_INSERT, 7'd1, 32'd9);
    send_request(ACT_INSERT, 7'd127, 32'd9);
    send_request(ACT_PUSH_BACK, 7'd64, 32'h8000_0000);
    send_request(ACT_PUSH_FRONT, 7'd127, 32'h7FFF_FFFF);
    send_request(ACT_INSERT, 7'd1, 32'h0000_0000);
    send_request(ACT_INSERT, 7'd3, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 7'd5, 32'd1);
    send_request(ACT_FIND, 7'd0, 32'h8000_0000);
    send_request(ACT_FIND, 7'd99, 32'hFFFF_FFFF);
    send_request(ACT_FIND, 7'd0, 32'hA5A5_5A5A);
    send_request(ACT_PUSH_BACK, 7'd0, 32'h0000_0000);
    send_request(ACT_FIND, 7'd0, 32'h0000_0000);
    send_request(ACT_MODIFY, 7'd2, 32'h5A5A_A5A5);
    send_request(ACT_MODIFY, 7'd5, 32'd3);
    send_request(ACT_ERASE, 7'd1, 32'd0);
    send_request(ACT_ERASE, 7'd4, 32'd0);
    send_request(ACT_POP_BACK, 7'd64, 32'd0);
    send_request(ACT_POP_FRONT, 7'd64, 32'd0);
    send_request(ACT_FIND, 7'd0, 32'h5A5A_A5A5);
  endtask

  // Fills the list to capacity, tries to grow it further, then empties it.
  task automatic test_full_list();
    while (list_q.size() < OALE_CAPACITY) begin
      send_request(ACT_PUSH_BACK, 7'd0, 32'h1000_0000 + list_q.size());
    end
    send_request(ACT_FIND, 7'd0, 32'h1000_0000 + OALE_CAPACITY - 1);
    send_request(ACT_FIND, 7'd0, 32'h2000_0000);
    send_request(ACT_PUSH_BACK, 7'd0, 32'd1);
    send_request(ACT_PUSH_FRONT, 7'd0, 32'd1);
    send_request(ACT_INSERT, 7'd64, 32'd1);
    send_request(ACT_INSERT, 7'd65, 32'd1);
    send_request(ACT_MODIFY, 7'd63, 32'h8000_0000);
    send_request(ACT_MODIFY, 7'd64, 32'd1);
    wait_drained();
    while (list_q.size() != 0) begin
      send_request(pick_action(MIX_SHRINK), pick_position(ACT_ERASE), pick_value());
    end
    send_request(ACT_POP_FRONT, 7'd0, 32'd0);
  endtask

  // Random requests in grow, shrink and mixed phases, mostly well formed.
  task automatic test_random_list();
    mix_e mix;
    action_e act;
    mix = MIX_GROW;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) mix = mix_e'($urandom_range(0, 2));
      if (list_q.size() == OALE_CAPACITY && $urandom_range(0, 3) == 0) mix = MIX_SHRINK;
      if (list_q.size() == 0 && $urandom_range(0, 3) == 0) mix = MIX_GROW;
      steady = (i >= 600 && i < 900);
      if (i == 1000) wait_drained();
      act = pick_action(mix);
      send_request(act, pick_position(act), pick_value());
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_ready_i = 1'b0;
    steady = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_list();
    test_full_list();
    test_random_list();
    wait_drained();
    repeat (OALE_CAPACITY + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/oale_pkg.sv
src/oale_cell.sv
src/oale_ctrl.sv
src/ordered_array_list_engine.sv
test/ordered_array_list_engine_tb.sv
